// ----- rtl/lzssd_pkg.sv -----
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared types and format constants for the decompressor block.
// ----------------------------------------------------------------------------
`default_nettype none

package lzssd_pkg;

    localparam int WIN_AW = 12;
    localparam int CNT_W  = 5;

    localparam logic [31:0] SIGNATURE = 32'h5450574D;
    localparam logic [4:0]  MIN_MATCH = 5'd3;

    localparam logic [1:0] ST_DATA    = 2'd0;
    localparam logic [1:0] ST_BAD_SIG = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;

    typedef enum logic [1:0] {
        CMD_LIT,
        CMD_MATCH,
        CMD_STAT
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data;
        logic [WIN_AW-1:0]  offset;
        logic [CNT_W-1:0]   count;
        logic               last;
        logic [1:0]         status;
    } t_cmd;

    typedef struct packed {
        logic clearing;
    } t_back_stat;

endpackage

`default_nettype wire

// ----- rtl/lzssd_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssd_ram #(
    parameter int W = 8,
    parameter int D = 4096
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic                 i_re,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lzssd_front.sv -----
// ----------------------------------------------------------------------------
// LZSS decompressor front end
// Parses the header and flag bytes and turns the stream into commands.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_accept,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_start,
    output logic               o_push,
    output lzssd_pkg::t_cmd    o_cmd
);

    import lzssd_pkg::*;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_FLAG,
        PH_ITEM,
        PH_MATCH2,
        PH_DONE
    } t_phase;

    t_phase      r_phase, n_phase, e_phase;
    logic [2:0]  r_idx, n_idx, e_idx;
    logic [31:0] r_acc, n_acc, e_acc;
    logic [31:0] r_rem, n_rem, e_rem;
    logic [7:0]  r_flags, n_flags, e_flags;
    logic [3:0]  r_fpos, n_fpos, e_fpos;
    logic [7:0]  r_mfirst, n_mfirst, e_mfirst;

    logic [31:0]      shifted;
    logic [31:0]      placed;
    logic [CNT_W-1:0] mcount;
    logic [3:0]       fpos_dec;
    logic [31:0]      rem_dec;

    always_comb begin
        e_phase  = i_start ? PH_HEADER : r_phase;
        e_idx    = i_start ? 3'd0 : r_idx;
        e_acc    = i_start ? 32'd0 : r_acc;
        e_rem    = i_start ? 32'd0 : r_rem;
        e_flags  = i_start ? 8'd0 : r_flags;
        e_fpos   = i_start ? 4'd0 : r_fpos;
        e_mfirst = i_start ? 8'd0 : r_mfirst;

        shifted  = {e_acc[23:0], i_byte};
        case (e_idx[1:0])
            2'd0:    placed = e_acc | {24'd0, i_byte};
            2'd1:    placed = e_acc | {16'd0, i_byte, 8'd0};
            2'd2:    placed = e_acc | {8'd0, i_byte, 16'd0};
            default: placed = e_acc | {i_byte, 24'd0};
        endcase
        mcount   = {1'b0, e_mfirst[3:0]} + MIN_MATCH;
        fpos_dec = e_fpos - 4'd1;
        rem_dec  = e_rem - 32'd1;

        n_phase  = e_phase;
        n_idx    = e_idx;
        n_acc    = e_acc;
        n_rem    = e_rem;
        n_flags  = e_flags;
        n_fpos   = e_fpos;
        n_mfirst = e_mfirst;

        o_push        = 1'b0;
        o_cmd.kind    = CMD_LIT;
        o_cmd.data    = i_byte;
        o_cmd.offset  = {e_mfirst[7:4], i_byte};
        o_cmd.count   = mcount;
        o_cmd.last    = 1'b0;
        o_cmd.status  = ST_DATA;

        case (e_phase)
            PH_HEADER: begin
                if (!e_idx[2]) begin
                    n_acc = shifted;
                    n_idx = e_idx + 3'd1;
                    if (e_idx == 3'd3) begin
                        n_acc = 32'd0;
                        if (shifted != SIGNATURE) begin
                            o_push       = 1'b1;
                            o_cmd.kind   = CMD_STAT;
                            o_cmd.last   = 1'b1;
                            o_cmd.status = ST_BAD_SIG;
                            n_phase      = PH_DONE;
                            n_idx        = 3'd0;
                        end
                    end
                end else begin
                    n_acc = placed;
                    if (e_idx == 3'd7) begin
                        n_rem = placed;
                        n_idx = 3'd0;
                        if (placed == 32'd0) begin
                            o_push       = 1'b1;
                            o_cmd.kind   = CMD_STAT;
                            o_cmd.last   = 1'b1;
                            o_cmd.status = ST_EMPTY;
                            n_phase      = PH_DONE;
                        end else begin
                            n_phase = PH_FLAG;
                        end
                    end else begin
                        n_idx = e_idx + 3'd1;
                    end
                end
            end
            PH_FLAG: begin
                n_flags = i_byte;
                n_fpos  = 4'd8;
                n_phase = PH_ITEM;
            end
            PH_ITEM: begin
                if (e_flags[7]) begin
                    n_mfirst = i_byte;
                    n_phase  = PH_MATCH2;
                end else begin
                    o_push     = 1'b1;
                    o_cmd.kind = CMD_LIT;
                    o_cmd.last = (rem_dec == 32'd0);
                    n_rem      = rem_dec;
                    if (rem_dec == 32'd0) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_flags = {e_flags[6:0], 1'b0};
                        n_fpos  = fpos_dec;
                        n_phase = (fpos_dec == 4'd0) ? PH_FLAG : PH_ITEM;
                    end
                end
            end
            PH_MATCH2: begin
                o_push     = 1'b1;
                o_cmd.kind = CMD_MATCH;
                if (e_rem <= {27'd0, mcount}) begin
                    o_cmd.count = e_rem[CNT_W-1:0];
                    o_cmd.last  = 1'b1;
                    n_rem       = 32'd0;
                    n_phase     = PH_DONE;
                end else begin
                    n_rem   = e_rem - {27'd0, mcount};
                    n_flags = {e_flags[6:0], 1'b0};
                    n_fpos  = fpos_dec;
                    n_phase = (fpos_dec == 4'd0) ? PH_FLAG : PH_ITEM;
                end
            end
            default: begin
                n_phase = PH_DONE;
            end
        endcase

        o_push = o_push & i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HEADER;
            r_idx    <= 3'd0;
            r_acc    <= 32'd0;
            r_rem    <= 32'd0;
            r_flags  <= 8'd0;
            r_fpos   <= 4'd0;
            r_mfirst <= 8'd0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_acc    <= n_acc;
            r_rem    <= n_rem;
            r_flags  <= n_flags;
            r_fpos   <= n_fpos;
            r_mfirst <= n_mfirst;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lzssd_fifo.sv -----
// ----------------------------------------------------------------------------
// LZSS decompressor command queue
// Short register queue that decouples the parser from the copy engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssd_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire lzssd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output lzssd_pkg::t_cmd    o_cmd
);

    import lzssd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lzssd_back.sv -----
// ----------------------------------------------------------------------------
// LZSS decompressor copy engine
// Executes queued commands against the history window and drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssd_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_empty,
    input  wire lzssd_pkg::t_cmd  i_cmd,
    output logic                  o_pop,
    output lzssd_pkg::t_back_stat o_stat,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last,
    output logic [1:0]            o_out_status
);

    import lzssd_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_MREAD,
        S_MWRITE
    } t_state;

    t_state            r_state, n_state;
    logic [WIN_AW-1:0] r_wp, n_wp;
    logic [WIN_AW-1:0] r_clr, n_clr;
    logic [WIN_AW-1:0] r_off, n_off;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_last, n_last;
    logic              n_load;
    logic [7:0]        n_byte;
    logic              n_olast;
    logic [1:0]        n_status;

    logic              space;
    logic              ram_we, ram_re;
    logic [WIN_AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;

    lzssd_ram #(
        .W(8),
        .D(1 << WIN_AW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign space           = !o_out_valid || i_out_ready;
    assign o_stat.clearing = (r_state == S_CLEAR);

    always_comb begin
        n_state   = r_state;
        n_wp      = r_wp;
        n_clr     = r_clr;
        n_off     = r_off;
        n_cnt     = r_cnt;
        n_last    = r_last;
        n_load    = 1'b0;
        n_byte    = 8'd0;
        n_olast   = 1'b0;
        n_status  = ST_DATA;
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_wp;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = r_wp - r_off;

        case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = 8'd0;
                n_clr     = r_clr + WIN_AW'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_empty) begin
                    case (i_cmd.kind)
                        CMD_MATCH: begin
                            o_pop   = 1'b1;
                            n_off   = i_cmd.offset;
                            n_cnt   = i_cmd.count;
                            n_last  = i_cmd.last;
                            n_state = S_MREAD;
                        end
                        CMD_LIT: begin
                            if (space) begin
                                o_pop     = 1'b1;
                                ram_we    = 1'b1;
                                ram_wdata = i_cmd.data;
                                n_wp      = r_wp + WIN_AW'(1);
                                n_load    = 1'b1;
                                n_byte    = i_cmd.data;
                                n_olast   = i_cmd.last;
                            end
                        end
                        default: begin
                            if (space) begin
                                o_pop    = 1'b1;
                                n_load   = 1'b1;
                                n_olast  = 1'b1;
                                n_status = i_cmd.status;
                            end
                        end
                    endcase
                end
            end
            S_MREAD: begin
                ram_re  = 1'b1;
                n_state = S_MWRITE;
            end
            S_MWRITE: begin
                if (space) begin
                    ram_we  = 1'b1;
                    n_wp    = r_wp + WIN_AW'(1);
                    n_load  = 1'b1;
                    n_byte  = ram_rdata;
                    n_olast = r_last && (r_cnt == CNT_W'(1));
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = (r_cnt == CNT_W'(1)) ? S_IDLE : S_MREAD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_wp        <= '0;
            r_clr       <= '0;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wp    <= n_wp;
            r_clr   <= n_clr;
            if (n_load) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
        r_off  <= n_off;
        r_cnt  <= n_cnt;
        r_last <= n_last;
        if (n_load) begin
            o_out_byte   <= n_byte;
            o_out_last   <= n_olast;
            o_out_status <= n_status;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/lzss_stream_decompressor_unit.sv -----
// ----------------------------------------------------------------------------
// LZSS stream decompressor
// Compressed bytes enter on the input channel; decompressed bytes and status
// results leave on the output channel, both with valid/ready handshakes.
//
// The parser takes one compressed byte per cycle while its command queue has
// room. A literal leaves the copy engine in the cycle after it is dequeued. A
// match is dispatched from the idle state, then each output byte takes a read
// state and a write state: a registered read of the window, then a write. The
// window RAM port therefore sets the throughput of back references. Flag bytes
// make no commands; a header makes one only for a bad signature or zero length.
//
// After reset the 4096-byte window is swept to zero, one entry per cycle;
// the input ready stays low until the sweep ends.
// When the receiver stalls, the output register holds its item, the copy
// engine waits, the queue fills, and then the input ready drops.
// A byte with stream start set restarts the parser; the window and the write
// position carry over from the previous stream.
// ----------------------------------------------------------------------------
`default_nettype none

module lzss_stream_decompressor_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_stream_start,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_byte,
    output logic            o_out_last,
    output logic [1:0]      o_out_status
);

    import lzssd_pkg::*;

    logic       accept;
    logic       push, pop, full, empty;
    t_cmd       front_cmd, head_cmd;
    t_back_stat back_stat;

    assign o_in_ready = !full && !back_stat.clearing;
    assign accept     = i_in_valid && o_in_ready;

    lzssd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in_byte),
        .i_start  (i_stream_start),
        .o_push   (push),
        .o_cmd    (front_cmd)
    );

    lzssd_fifo #(
        .DEPTH(FIFO_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    lzssd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_stat       (back_stat),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_out_status (o_out_status)
    );

endmodule

`default_nettype wire

// ----- rtl/lzssd_checker.sv -----
// ----------------------------------------------------------------------------
// LZSS decompressor port checker
// Concurrent checks on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
`default_nettype none

module lzssd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_in_ready,
    input wire logic       o_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] o_out_byte,
    input wire logic       o_out_last,
    input wire logic [1:0] o_out_status
);

    import lzssd_pkg::*;

    a_ready_low_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_in_ready)
        else $error("input ready high right after reset");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_out_valid)
        else $error("output valid right after reset");

    a_status_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_status != ST_DATA) |-> o_out_last && (o_out_byte == 8'd0))
        else $error("status item is not a final zero item");

    a_output_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_byte)
            && $stable(o_out_last) && $stable(o_out_status))
        else $error("stalled output item changed");

endmodule

bind lzss_stream_decompressor_unit lzssd_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_in_ready   (o_in_ready),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_byte   (o_out_byte),
    .o_out_last   (o_out_last),
    .o_out_status (o_out_status)
);

`default_nettype wire

// ----- bench/lzss_stream_decompressor_unit_tb.sv -----
// ----------------------------------------------------------------------------
// LZSS stream decompressor testbench
// Feeds directed and random compressed streams through the input channel,
// idling both sides at random until CALM_ITEMS bytes are fed. Fixed records or
// a local decoder model predict outputs; each is compared with the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lzss_stream_decompressor_unit_tb;

    import lzssd_pkg::*;

    localparam int RANDOM_ITEMS = 350;
    localparam int CALM_ITEMS   = 300;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 100;

    typedef enum logic [2:0] {
        PH_HDR,
        PH_FLAGS,
        PH_TOKEN,
        PH_MATCH_LO,
        PH_FINISHED
    } t_parse_ph;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [1:0] status;
    } t_out_rec;

    typedef struct packed {
        logic [7:0] b;
        logic       s;
        logic       fixed;
        logic       has;
        t_out_rec   rec;
    } t_stim_row;

    localparam t_out_rec NO_REC    = '0;
    localparam t_out_rec BAD_REC   = '{8'h00, 1'b1, ST_BAD_SIG};
    localparam t_out_rec EMPTY_REC = '{8'h00, 1'b1, ST_EMPTY};
    localparam t_out_rec LIT_FF    = '{8'hFF, 1'b0, ST_DATA};

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_in_byte;
    logic       i_stream_start;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_byte;
    logic       o_out_last;
    logic [1:0] o_out_status;

    logic [7:0]  win_mem [4096];
    logic [11:0] wr_pos;
    logic [31:0] remaining;
    logic [2:0]  hdr_idx;
    logic [31:0] hdr_acc;
    logic [7:0]  flags;
    logic [3:0]  flag_cnt;
    logic [7:0]  match_hi;
    t_parse_ph   ph;

    t_out_rec new_out [$];
    t_out_rec pending_out [$];

    int  errors      = 0;
    int  item_count  = 0;
    int  cycle_count = 0;
    logic calm       = 1'b0;

    t_stim_row directed_rows [0:29] = '{
        '{8'h58, 1'b1, 1'b1, 1'b0, NO_REC},
        '{8'h50, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h57, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h4D, 1'b0, 1'b1, 1'b1, BAD_REC},
        '{8'hFF, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h54, 1'b1, 1'b1, 1'b0, NO_REC},
        '{8'h50, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h57, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h4D, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_REC},
        '{8'h54, 1'b1, 1'b1, 1'b0, NO_REC},
        '{8'h50, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h57, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h4D, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h18, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'h70, 1'b0, 1'b1, 1'b0, NO_REC},
        '{8'hFF, 1'b0, 1'b1, 1'b1, LIT_FF},
        '{8'h0F, 1'b0, 1'b0, 1'b0, NO_REC},
        '{8'hFF, 1'b0, 1'b0, 1'b0, NO_REC},
        '{8'hF0, 1'b0, 1'b0, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
        '{8'h00, 1'b0, 1'b0, 1'b0, NO_REC},
        '{8'hAA, 1'b0, 1'b0, 1'b0, NO_REC}
    };

    lzss_stream_decompressor_unit u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_in_byte      (i_in_byte),
        .i_stream_start (i_stream_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_byte     (o_out_byte),
        .o_out_last     (o_out_last),
        .o_out_status   (o_out_status)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    task automatic report_mismatch(input string what, input int got, input int want);
        errors++;
        if (errors <= 100) begin
            $display("mismatch at cycle %0d: %s got %0h expected %0h",
                     cycle_count, what, got, want);
        end
    endtask

    function automatic void clear_decoder();
        for (int i = 0; i < 4096; i++) begin
            win_mem[i] = 8'h00;
        end
        wr_pos    = '0;
        remaining = '0;
        hdr_idx   = '0;
        hdr_acc   = '0;
        flags     = '0;
        flag_cnt  = '0;
        match_hi  = '0;
        ph        = PH_HDR;
    endfunction

    function automatic logic emit_out(input logic [7:0] v);
        logic fin;
        win_mem[wr_pos] = v;
        wr_pos    = wr_pos + 12'd1;
        remaining = remaining - 32'd1;
        fin       = (remaining == 32'd0);
        new_out.push_back('{data: v, last: fin, status: ST_DATA});
        if (fin) begin
            ph = PH_FINISHED;
        end
        return fin;
    endfunction

    function automatic void next_token();
        flags    = flags << 1;
        flag_cnt = flag_cnt - 4'd1;
        ph       = (flag_cnt == 4'd0) ? PH_FLAGS : PH_TOKEN;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic s);
        logic [11:0] off;
        logic [4:0]  cnt;
        logic [11:0] rd;
        logic        fin;
        new_out.delete();
        if (s) begin
            hdr_idx   = '0;
            hdr_acc   = '0;
            remaining = '0;
            flags     = '0;
            flag_cnt  = '0;
            match_hi  = '0;
            ph        = PH_HDR;
        end
        case (ph)
            PH_HDR: begin
                if (hdr_idx < 3'd4) begin
                    hdr_acc = {hdr_acc[23:0], b};
                    if (hdr_idx == 3'd3 && hdr_acc != SIGNATURE) begin
                        new_out.push_back(BAD_REC);
                        ph      = PH_FINISHED;
                        hdr_idx = '0;
                        hdr_acc = '0;
                    end else begin
                        if (hdr_idx == 3'd3) begin
                            hdr_acc = '0;
                        end
                        hdr_idx = hdr_idx + 3'd1;
                    end
                end else begin
                    hdr_acc = hdr_acc | (32'(b) << {hdr_idx[1:0], 3'b000});
                    if (hdr_idx == 3'd7) begin
                        remaining = hdr_acc;
                        hdr_idx   = '0;
                        if (remaining == 32'd0) begin
                            new_out.push_back(EMPTY_REC);
                            ph = PH_FINISHED;
                        end else begin
                            ph = PH_FLAGS;
                        end
                    end else begin
                        hdr_idx = hdr_idx + 3'd1;
                    end
                end
            end
            PH_FLAGS: begin
                flags    = b;
                flag_cnt = 4'd8;
                ph       = PH_TOKEN;
            end
            PH_TOKEN: begin
                if (flags[7]) begin
                    match_hi = b;
                    ph       = PH_MATCH_LO;
                end else if (!emit_out(b)) begin
                    next_token();
                end
            end
            PH_MATCH_LO: begin
                off = {match_hi[7:4], b};
                cnt = {1'b0, match_hi[3:0]} + MIN_MATCH;
                fin = 1'b0;
                for (int i = 0; i < int'(cnt) && !fin; i++) begin
                    rd  = wr_pos - off;
                    fin = emit_out(win_mem[rd]);
                end
                if (!fin) begin
                    next_token();
                end
            end
            default: ph = PH_FINISHED;
        endcase
    endfunction

    task automatic feed(input logic [7:0] b, input logic s, input logic fixed,
                        input logic has, input t_out_rec fx);
        logic ignored;
        ignored = (ph == PH_FINISHED) && !s;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_in_byte      <= b;
        i_stream_start <= s;
        do @(posedge i_clk); while (!o_in_ready);
        decode_byte(b, s);
        if (fixed) begin
            if (has) begin
                pending_out.push_back(fx);
            end
        end else begin
            foreach (new_out[k]) begin
                pending_out.push_back(new_out[k]);
            end
        end
        if (!ignored) begin
            item_count++;
        end
        if (item_count >= CALM_ITEMS) begin
            calm = 1'b1;
        end
    endtask

    task automatic run_stream();
        int          kind;
        int          limit_n;
        int          sent;
        int          k;
        logic [31:0] len;
        logic [7:0]  sig [4];
        logic [7:0]  b;
        kind = int'($urandom_range(0, 15));
        sig  = '{8'h54, 8'h50, 8'h57, 8'h4D};
        if (kind == 0) begin
            k = int'($urandom_range(0, 3));
            sig[k] = sig[k] ^ 8'($urandom_range(1, 255));
        end
        for (k = 0; k < 4; k++) begin
            feed(sig[k], k == 0, 1'b0, 1'b0, NO_REC);
        end
        if (kind != 0) begin
            if (kind == 1) begin
                len = '0;
            end else if (kind == 2) begin
                len = $urandom();
            end else if ($urandom_range(0, 7) == 0) begin
                len = $urandom_range(41, 200);
            end else begin
                len = $urandom_range(1, 40);
            end
            for (k = 0; k < 4; k++) begin
                feed(len[8*k +: 8], 1'b0, 1'b0, 1'b0, NO_REC);
            end
            limit_n = (kind == 2) ? int'($urandom_range(1, 60)) : 32'h3FFF_FFFF;
            sent = 0;
            while (ph != PH_FINISHED && sent < limit_n && item_count < RANDOM_ITEMS) begin
                case (ph)
                    PH_TOKEN: begin
                        if (flags[7]) begin
                            b = {($urandom_range(0, 1) != 0) ? 4'h0 : 4'($urandom()),
                                 4'($urandom())};
                        end else begin
                            b = 8'($urandom());
                        end
                    end
                    PH_MATCH_LO: begin
                        b = ($urandom_range(0, 1) != 0) ? 8'($urandom_range(1, 16))
                                                        : 8'($urandom());
                    end
                    default: b = 8'($urandom());
                endcase
                feed(b, 1'b0, 1'b0, 1'b0, NO_REC);
                sent++;
            end
        end
        if (ph == PH_FINISHED && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) feed(8'($urandom()), 1'b0, 1'b0, 1'b0, NO_REC);
        end
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                stall_left = int'($urandom_range(1, 13)) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        t_out_rec want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                if (pending_out.size() == 0) begin
                    report_mismatch("unexpected item, byte", int'(o_out_byte), 0);
                end else begin
                    want = pending_out.pop_front();
                    if (o_out_byte !== want.data) begin
                        report_mismatch("out_byte", int'(o_out_byte), int'(want.data));
                    end
                    if (o_out_last !== want.last) begin
                        report_mismatch("last", int'(o_out_last), int'(want.last));
                    end
                    if (o_out_status !== want.status) begin
                        report_mismatch("status", int'(o_out_status), int'(want.status));
                    end
                end
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_in_byte      <= 8'h00;
        i_stream_start <= 1'b0;
        clear_decoder();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < 30; r++) begin
            feed(directed_rows[r].b, directed_rows[r].s, directed_rows[r].fixed,
                 directed_rows[r].has, directed_rows[r].rec);
        end

        item_count = 0;
        while (item_count < RANDOM_ITEMS) begin
            run_stream();
        end
        i_in_valid <= 1'b0;

        while (pending_out.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_out.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
